// File: src/request_message_validator_top_assert.svh
// Assertion macros for the request message validator.
`ifndef REQUEST_MESSAGE_VALIDATOR_TOP_ASSERT_SVH
`define REQUEST_MESSAGE_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RMV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("request validator check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("request validator check failed");

`endif

// File: src/rmv_pkg.sv
// Shared types, codes and constants of the request message validator.
package rmv_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_MAJOR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_MINOR  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ROLE     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOVER_TYPE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_PROP_TYPE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROP_TYPE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCRIPTOR_TYPE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN       = 4'd7;

  localparam logic [7:0] RST_SUPPORTED_MAJOR = 8'd1;
  localparam logic [7:0] RST_SUPPORTED_MINOR = 8'd0;
  localparam logic [7:0] RST_REQUEST_ROLE    = 8'd0;
  localparam logic [7:0] RST_DISCOVER_TYPE   = 8'd1;
  localparam logic [7:0] RST_READ_PROP_TYPE  = 8'd2;
  localparam logic [7:0] RST_WRITE_PROP_TYPE = 8'd3;
  localparam logic [7:0] RST_DESCRIPTOR_TYPE = 8'd4;
  localparam logic       RST_BIG_ENDIAN      = 1'b0;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam logic [3:0] OUT_DISCOVER_OK   = 4'd0;
  localparam logic [3:0] OUT_DISCOVER_BAD  = 4'd1;
  localparam logic [3:0] OUT_READ_OK       = 4'd2;
  localparam logic [3:0] OUT_READ_BAD      = 4'd3;
  localparam logic [3:0] OUT_WRITE_OK      = 4'd4;
  localparam logic [3:0] OUT_WRITE_BAD     = 4'd5;
  localparam logic [3:0] OUT_DESCRIPTOR_OK = 4'd6;
  localparam logic [3:0] OUT_DESCRIPTOR_BAD = 4'd7;
  localparam logic [3:0] OUT_BAD_VERSION   = 4'd8;
  localparam logic [3:0] OUT_UNSUPPORTED   = 4'd9;

  typedef struct packed {
    logic [7:0] supported_major;
    logic [7:0] supported_minor;
    logic [7:0] request_role_code;
    logic [7:0] discover_type_code;
    logic [7:0] read_prop_type_code;
    logic [7:0] write_prop_type_code;
    logic [7:0] descriptor_type_code;
    logic       big_endian_lengths;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic [7:0]  message_type;
    logic [7:0]  role;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef enum logic [6:0] {
    CLS_NONE        = 7'b0000001,
    CLS_DISCOVER    = 7'b0000010,
    CLS_READ        = 7'b0000100,
    CLS_WRITE       = 7'b0001000,
    CLS_DESCRIPTOR  = 7'b0010000,
    CLS_BAD_VERSION = 7'b0100000,
    CLS_UNSUPPORTED = 7'b1000000
  } class_t;

  typedef enum logic [8:0] {
    PH_LEN0_A = 9'b000000001,
    PH_LEN0_B = 9'b000000010,
    PH_STR0   = 9'b000000100,
    PH_LEN1_A = 9'b000001000,
    PH_LEN1_B = 9'b000010000,
    PH_STR1   = 9'b000100000,
    PH_TAG    = 9'b001000000,
    PH_VALUE  = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

endpackage

// File: src/rmv_cfg_regs.sv
// Configuration register file of the request message validator.
module rmv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rmv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data,
  output rmv_pkg::cfg_t                    cfg
);

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.supported_major      <= rmv_pkg::RST_SUPPORTED_MAJOR;
      cfg.supported_minor      <= rmv_pkg::RST_SUPPORTED_MINOR;
      cfg.request_role_code    <= rmv_pkg::RST_REQUEST_ROLE;
      cfg.discover_type_code   <= rmv_pkg::RST_DISCOVER_TYPE;
      cfg.read_prop_type_code  <= rmv_pkg::RST_READ_PROP_TYPE;
      cfg.write_prop_type_code <= rmv_pkg::RST_WRITE_PROP_TYPE;
      cfg.descriptor_type_code <= rmv_pkg::RST_DESCRIPTOR_TYPE;
      cfg.big_endian_lengths   <= rmv_pkg::RST_BIG_ENDIAN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rmv_pkg::CFG_SUPPORTED_MAJOR: cfg.supported_major      <= cfg_data;
        rmv_pkg::CFG_SUPPORTED_MINOR: cfg.supported_minor      <= cfg_data;
        rmv_pkg::CFG_REQUEST_ROLE:    cfg.request_role_code    <= cfg_data;
        rmv_pkg::CFG_DISCOVER_TYPE:   cfg.discover_type_code   <= cfg_data;
        rmv_pkg::CFG_READ_PROP_TYPE:  cfg.read_prop_type_code  <= cfg_data;
        rmv_pkg::CFG_WRITE_PROP_TYPE: cfg.write_prop_type_code <= cfg_data;
        rmv_pkg::CFG_DESCRIPTOR_TYPE: cfg.descriptor_type_code <= cfg_data;
        rmv_pkg::CFG_BIG_ENDIAN:      cfg.big_endian_lengths   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/rmv_parser.sv
// Message state and per-item validation logic of the request message validator.
module rmv_parser #(
  parameter int LENGTH_BITS = rmv_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  rmv_pkg::item_t item,
  input  rmv_pkg::cfg_t  cfg,
  output logic           result_valid,
  output logic [3:0]     result_outcome
);

  rmv_pkg::class_t          msg_class, msg_class_next, hdr_class;
  rmv_pkg::phase_t          parse_phase, parse_phase_next;
  logic [LENGTH_BITS-1:0]   bytes_left, bytes_left_next, hdr_len;
  logic [15:0]              string_left, string_left_next, prefix_len, string_dec;
  logic [7:0]               first_length_byte, first_length_byte_next;
  logic                     failed_flag, failed_flag_next, hdr_failed, parses;

  function automatic logic [3:0] finish_code(rmv_pkg::class_t c, rmv_pkg::phase_t p,
                                             logic failed);
    logic bad;
    bad = failed || (p != rmv_pkg::PH_DONE);
    case (c)
      rmv_pkg::CLS_DISCOVER:
        finish_code = failed ? rmv_pkg::OUT_DISCOVER_BAD : rmv_pkg::OUT_DISCOVER_OK;
      rmv_pkg::CLS_READ:
        finish_code = bad ? rmv_pkg::OUT_READ_BAD : rmv_pkg::OUT_READ_OK;
      rmv_pkg::CLS_WRITE:
        finish_code = bad ? rmv_pkg::OUT_WRITE_BAD : rmv_pkg::OUT_WRITE_OK;
      rmv_pkg::CLS_DESCRIPTOR:
        finish_code = bad ? rmv_pkg::OUT_DESCRIPTOR_BAD : rmv_pkg::OUT_DESCRIPTOR_OK;
      rmv_pkg::CLS_BAD_VERSION: finish_code = rmv_pkg::OUT_BAD_VERSION;
      default:                  finish_code = rmv_pkg::OUT_UNSUPPORTED;
    endcase
  endfunction

  assign hdr_len    = LENGTH_BITS'(item.payload_length);
  assign prefix_len = cfg.big_endian_lengths ? {first_length_byte, item.data_byte}
                                             : {item.data_byte, first_length_byte};
  assign string_dec = string_left - 16'd1;
  assign parses     = ((msg_class == rmv_pkg::CLS_READ) ||
                       (msg_class == rmv_pkg::CLS_WRITE) ||
                       (msg_class == rmv_pkg::CLS_DESCRIPTOR)) && !failed_flag;

  always_comb begin
    if ((item.major_version != cfg.supported_major) ||
        (item.minor_version != cfg.supported_minor)) begin
      hdr_class = rmv_pkg::CLS_BAD_VERSION;
    end else if (item.message_type == cfg.discover_type_code) begin
      hdr_class = rmv_pkg::CLS_DISCOVER;
    end else if (item.message_type == cfg.read_prop_type_code) begin
      hdr_class = rmv_pkg::CLS_READ;
    end else if (item.message_type == cfg.write_prop_type_code) begin
      hdr_class = rmv_pkg::CLS_WRITE;
    end else if (item.message_type == cfg.descriptor_type_code) begin
      hdr_class = rmv_pkg::CLS_DESCRIPTOR;
    end else begin
      hdr_class = rmv_pkg::CLS_UNSUPPORTED;
    end
    hdr_failed = ((hdr_class != rmv_pkg::CLS_BAD_VERSION) &&
                  (hdr_class != rmv_pkg::CLS_UNSUPPORTED) &&
                  (item.role != cfg.request_role_code)) ||
                 ((hdr_class == rmv_pkg::CLS_DISCOVER) && (hdr_len != '0));
  end

  always_comb begin
    msg_class_next         = msg_class;
    parse_phase_next       = parse_phase;
    bytes_left_next        = bytes_left;
    string_left_next       = string_left;
    first_length_byte_next = first_length_byte;
    failed_flag_next       = failed_flag;
    result_valid           = 1'b0;
    result_outcome         = rmv_pkg::OUT_DISCOVER_OK;
    if (step) begin
      if (item.kind == rmv_pkg::KIND_HEADER) begin
        parse_phase_next       = rmv_pkg::PH_LEN0_A;
        string_left_next       = '0;
        first_length_byte_next = '0;
        failed_flag_next       = hdr_failed;
        bytes_left_next        = hdr_len;
        msg_class_next         = hdr_class;
        if (hdr_len == '0) begin
          result_valid   = 1'b1;
          result_outcome = finish_code(hdr_class, rmv_pkg::PH_LEN0_A, hdr_failed);
          msg_class_next = rmv_pkg::CLS_NONE;
        end
      end else if (msg_class != rmv_pkg::CLS_NONE) begin
        if (parses) begin
          case (parse_phase)
            rmv_pkg::PH_LEN0_A: begin
              first_length_byte_next = item.data_byte;
              parse_phase_next       = rmv_pkg::PH_LEN0_B;
            end
            rmv_pkg::PH_LEN1_A: begin
              first_length_byte_next = item.data_byte;
              parse_phase_next       = rmv_pkg::PH_LEN1_B;
            end
            rmv_pkg::PH_LEN0_B, rmv_pkg::PH_LEN1_B: begin
              if (prefix_len == 16'd0) begin
                failed_flag_next = 1'b1;
              end else begin
                string_left_next = prefix_len;
                parse_phase_next = (parse_phase == rmv_pkg::PH_LEN0_B) ?
                                   rmv_pkg::PH_STR0 : rmv_pkg::PH_STR1;
              end
            end
            rmv_pkg::PH_STR0, rmv_pkg::PH_STR1: begin
              string_left_next = string_dec;
              if (string_dec == 16'd0) begin
                if ((parse_phase == rmv_pkg::PH_STR0) &&
                    (msg_class != rmv_pkg::CLS_DESCRIPTOR)) begin
                  parse_phase_next = rmv_pkg::PH_LEN1_A;
                end else if (msg_class == rmv_pkg::CLS_WRITE) begin
                  parse_phase_next = rmv_pkg::PH_TAG;
                end else begin
                  parse_phase_next = rmv_pkg::PH_DONE;
                end
              end
            end
            rmv_pkg::PH_TAG: begin
              if (item.data_byte != 8'd1) failed_flag_next = 1'b1;
              else parse_phase_next = rmv_pkg::PH_VALUE;
            end
            rmv_pkg::PH_VALUE: begin
              if (item.data_byte > 8'd1) failed_flag_next = 1'b1;
              else parse_phase_next = rmv_pkg::PH_DONE;
            end
            default: failed_flag_next = 1'b1;
          endcase
        end
        bytes_left_next = bytes_left - LENGTH_BITS'(1);
        if (bytes_left_next == '0) begin
          result_valid   = 1'b1;
          result_outcome = finish_code(msg_class, parse_phase_next, failed_flag_next);
          msg_class_next = rmv_pkg::CLS_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_class         <= rmv_pkg::CLS_NONE;
      parse_phase       <= rmv_pkg::PH_LEN0_A;
      bytes_left        <= '0;
      string_left       <= '0;
      first_length_byte <= '0;
      failed_flag       <= 1'b0;
    end else begin
      msg_class         <= msg_class_next;
      parse_phase       <= parse_phase_next;
      bytes_left        <= bytes_left_next;
      string_left       <= string_left_next;
      first_length_byte <= first_length_byte_next;
      failed_flag       <= failed_flag_next;
    end
  end

endmodule

// File: src/request_message_validator_top.sv
// Top level of the request message validator: input register, parser, result register.
//
// Requests enter on the s_axis channel: tuser carries the kind (0 header,
// 1 payload byte), tdata the header fields or the payload byte. A header
// opens a message; its payload bytes follow one per request. One outcome
// code leaves on m_axis after the last payload byte, or right at a header
// whose payload length is zero. A new header drops an unfinished message.
// Registers are written through cfg_valid/cfg_index/cfg_data, which is
// ready whenever rst is low; write them only while no message is in flight.
// An outcome passes through the input register, then the result register,
// before it leaves on m_axis. Throughput: one request per cycle while
// m_axis does not stall. When m_axis stalls, a held outcome keeps the
// next request in the input register; outside reset, s_axis_tready drops
// only while both registers are full and m_axis stalls.
// Reset is synchronous: registers return to their defaults, no message is
// open, both registers are empty and both ready outputs are low.
module request_message_validator_top #(
  parameter int LENGTH_BITS = rmv_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // major_version[7:0], minor_version[15:8], message_type[23:16], role[31:24],
  // payload_length[47:32], data_byte[55:48]
  input  logic [55:0]                   s_axis_tdata,
  // kind[0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // outcome[3:0], zero[7:4]
  output logic [7:0]                    m_axis_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  rmv_pkg::cfg_t  cfg;
  rmv_pkg::item_t in_item;
  logic           in_valid;
  logic           advance;
  logic           res_valid;
  logic [3:0]     res_outcome;
  logic [3:0]     outcome;

  rmv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rmv_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (in_item),
    .cfg            (cfg),
    .result_valid   (res_valid),
    .result_outcome (res_outcome)
  );

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign m_axis_tdata  = {4'b0000, outcome};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind           <= s_axis_tuser[0];
      in_item.major_version  <= s_axis_tdata[7:0];
      in_item.minor_version  <= s_axis_tdata[15:8];
      in_item.message_type   <= s_axis_tdata[23:16];
      in_item.role           <= s_axis_tdata[31:24];
      in_item.payload_length <= s_axis_tdata[47:32];
      in_item.data_byte      <= s_axis_tdata[55:48];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      outcome <= res_outcome;
    end
  end

`include "request_message_validator_top_assert.svh"

  `RMV_ASSERT_NOW(a_ready_when_empty, !in_valid, s_axis_tready)
  `RMV_ASSERT_NOW(a_outcome_code, m_axis_tvalid, m_axis_tdata[3:0] <= rmv_pkg::OUT_UNSUPPORTED)
  `RMV_ASSERT_NEXT(a_hold_when_blocked, in_valid && m_axis_tvalid && !m_axis_tready, in_valid && m_axis_tvalid)

endmodule
